[hw/rtl/interval_arithmetic_unit_macros.svh]
// assertion helpers for the interval arithmetic unit
`ifndef INTERVAL_ARITHMETIC_UNIT_MACROS_SVH
`define INTERVAL_ARITHMETIC_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge out of reset
`define IAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iau check failed");
// next-cycle implication
`define IAU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iau check failed");
`else
`define IAU_ASSERT_IMP(lbl, ante, cons)
`define IAU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/iau_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package iau_pkg;

    localparam int WIDTH       = 32;
    localparam int FRAC_BITS   = 16;
    // quotient bits of 2^(2*frac) / |b|
    localparam int QW          = 2 * FRAC_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int IN_W        = 136;
    localparam int OUT_W       = 72;

    typedef logic signed [WIDTH-1:0] val_t;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_SPAN = 2'd1;
    localparam status_t ST_SAT  = 2'd2;

    typedef enum logic [2:0] {
        KIND_ADD  = 3'd0,
        KIND_SUB  = 3'd1,
        KIND_MUL  = 3'd2,
        KIND_DIV  = 3'd3,
        KIND_HULL = 3'd4
    } kind_t;

    // decoded operation, all zero for an unused kind
    typedef struct packed {
        logic add;
        logic sub;
        logic mul;
        logic div;
        logic hull;
    } op_t;

    typedef struct packed {
        op_t  op;
        logic span;
        val_t a_lo;
        val_t a_hi;
        val_t b_lo;
        val_t b_hi;
    } desc_t;

endpackage

`default_nettype wire

[hw/rtl/iau_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module iau_front (
    input  logic [2:0]      kind,
    input  iau_pkg::val_t   a_lo,
    input  iau_pkg::val_t   a_hi,
    input  iau_pkg::val_t   b_lo,
    input  iau_pkg::val_t   b_hi,
    output iau_pkg::desc_t  desc
);

    iau_pkg::op_t  op;
    iau_pkg::val_t bmin;
    iau_pkg::val_t bmax;

    always_comb
    begin
        op = '0;
        case (iau_pkg::kind_t'(kind))
            iau_pkg::KIND_ADD:  op.add  = 1'b1;
            iau_pkg::KIND_SUB:  op.sub  = 1'b1;
            iau_pkg::KIND_MUL:  op.mul  = 1'b1;
            iau_pkg::KIND_DIV:  op.div  = 1'b1;
            iau_pkg::KIND_HULL: op.hull = 1'b1;
            default:            op      = '0;
        endcase
    end

    // divisor interval touching or crossing zero
    always_comb
    begin
        bmin = ($signed(b_lo) < $signed(b_hi)) ? b_lo : b_hi;
        bmax = ($signed(b_lo) < $signed(b_hi)) ? b_hi : b_lo;
    end

    always_comb
    begin
        desc.op   = op;
        desc.span = op.div && ($signed(bmin) <= 0) && ($signed(bmax) >= 0);
        desc.a_lo = a_lo;
        desc.a_hi = a_hi;
        desc.b_lo = b_lo;
        desc.b_hi = b_hi;
    end

endmodule

`default_nettype wire

[hw/rtl/iau_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module iau_queue #(
    parameter int DEPTH = iau_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  iau_pkg::desc_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output iau_pkg::desc_t rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    iau_pkg::desc_t mem_reg [0:DEPTH-1];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           do_wr, do_rd;

    assign wr_ready = (cnt_reg != CW'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/iau_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module iau_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  iau_pkg::desc_t   in_desc,
    output logic             out_valid,
    input  logic             out_ready,
    output iau_pkg::val_t    res_lo,
    output iau_pkg::val_t    res_hi,
    output iau_pkg::status_t status
);

    localparam int W  = iau_pkg::WIDTH;
    localparam int F  = iau_pkg::FRAC_BITS;
    localparam int QW = iau_pkg::QW;

    typedef struct packed {
        logic         sat;
        logic [W-1:0] v;
    } clamp_t;

    typedef struct packed {
        logic [W-1:0]  rem;
        logic [QW-1:0] q;
    } div_t;

    function automatic clamp_t clamp_w(input logic signed [2*W-1:0] x);
        clamp_t                  r;
        logic signed [2*W-1:0]   vmax;
        logic signed [2*W-1:0]   vmin;
        vmax = {{(W+1){1'b0}}, {(W-1){1'b1}}};
        vmin = {{(W+1){1'b1}}, {(W-1){1'b0}}};
        r.sat = 1'b0;
        r.v   = x[W-1:0];
        if (x > vmax)
        begin
            r.sat = 1'b1;
            r.v   = vmax[W-1:0];
        end
        else if (x < vmin)
        begin
            r.sat = 1'b1;
            r.v   = vmin[W-1:0];
        end
        return r;
    endfunction

    // one restoring step, dividend bit nb shifted in
    function automatic div_t div_step(input div_t s, input logic [W-1:0] d, input logic nb);
        div_t       r;
        logic [W:0] sh;
        logic [W:0] diff;
        logic       ge;
        sh    = {s.rem, nb};
        diff  = sh - {1'b0, d};
        ge    = (sh >= {1'b0, d});
        r.rem = ge ? diff[W-1:0] : sh[W-1:0];
        r.q   = {s.q[QW-2:0], ge};
        return r;
    endfunction

    function automatic clamp_t recip_sat(input logic [QW-1:0] q, input logic neg);
        clamp_t        r;
        logic [QW-1:0] lim;
        logic [QW-1:0] qc;
        lim   = neg ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
        r.sat = (q > lim);
        qc    = r.sat ? lim : q;
        r.v   = neg ? (~qc[W-1:0] + 1'b1) : qc[W-1:0];
        return r;
    endfunction

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    logic en;

    // reciprocal pipeline
    logic           dv_reg  [0:QW];
    iau_pkg::desc_t dd_reg  [0:QW];
    div_t           s1_reg  [0:QW];
    div_t           s2_reg  [0:QW];
    logic [W-1:0]   d1_reg  [0:QW];
    logic [W-1:0]   d2_reg  [0:QW];
    div_t           s1_next [0:QW];
    div_t           s2_next [0:QW];

    // operand select
    logic           rc_v_reg;
    iau_pkg::desc_t rc_d_reg;
    iau_pkg::val_t  mb_lo_reg, mb_hi_reg, mb_lo_next, mb_hi_next;
    logic           rsat_reg, rsat_next;
    clamp_t         r1, r2;

    // products
    logic                  mp_v_reg;
    iau_pkg::desc_t        mp_d_reg;
    logic signed [2*W-1:0] mp_reg  [0:3];
    logic signed [2*W-1:0] mp_next [0:3];
    logic                  mp_sat_reg;

    // truncated products
    logic           tq_v_reg;
    iau_pkg::desc_t tq_d_reg;
    iau_pkg::val_t  tq_reg  [0:3];
    logic           tq_sat_reg, tq_sat_next;
    clamp_t         tq_c    [0:3];

    // output stage
    logic             out_v_reg;
    iau_pkg::val_t    res_lo_reg, res_lo_next;
    iau_pkg::val_t    res_hi_reg, res_hi_next;
    iau_pkg::status_t status_reg, status_next;

    assign en       = !out_v_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        s1_next[0].rem = '0;
        s1_next[0].q   = '0;
        s2_next[0].rem = '0;
        s2_next[0].q   = '0;
        for (int k = 0; k < QW; k++)
        begin
            s1_next[k+1] = div_step(s1_reg[k], d1_reg[k], (k == 0));
            s2_next[k+1] = div_step(s2_reg[k], d2_reg[k], (k == 0));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
            rc_v_reg  <= 1'b0;
            mp_v_reg  <= 1'b0;
            tq_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            dv_reg[0] <= in_valid;
            for (int k = 0; k < QW; k++)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
            rc_v_reg  <= dv_reg[QW];
            mp_v_reg  <= rc_v_reg;
            tq_v_reg  <= mp_v_reg;
            out_v_reg <= tq_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_reg[0] <= in_desc;
            s1_reg[0] <= s1_next[0];
            s2_reg[0] <= s2_next[0];
            d1_reg[0] <= mag(in_desc.b_hi);
            d2_reg[0] <= mag(in_desc.b_lo);
            for (int k = 0; k < QW; k++)
            begin
                dd_reg[k+1] <= dd_reg[k];
                s1_reg[k+1] <= s1_next[k+1];
                s2_reg[k+1] <= s2_next[k+1];
                d1_reg[k+1] <= d1_reg[k];
                d2_reg[k+1] <= d2_reg[k];
            end
        end
    end

    // reciprocals ordered into [min, max] for divide, b as is otherwise
    always_comb
    begin
        r1         = recip_sat(s1_reg[QW].q, dd_reg[QW].b_hi[W-1]);
        r2         = recip_sat(s2_reg[QW].q, dd_reg[QW].b_lo[W-1]);
        mb_lo_next = dd_reg[QW].b_lo;
        mb_hi_next = dd_reg[QW].b_hi;
        rsat_next  = 1'b0;
        if (dd_reg[QW].op.div)
        begin
            rsat_next = r1.sat || r2.sat;
            if ($signed(r1.v) < $signed(r2.v))
            begin
                mb_lo_next = r1.v;
                mb_hi_next = r2.v;
            end
            else
            begin
                mb_lo_next = r2.v;
                mb_hi_next = r1.v;
            end
        end
    end

    always_comb
    begin
        mp_next[0] = $signed(rc_d_reg.a_lo) * $signed(mb_lo_reg);
        mp_next[1] = $signed(rc_d_reg.a_lo) * $signed(mb_hi_reg);
        mp_next[2] = $signed(rc_d_reg.a_hi) * $signed(mb_lo_reg);
        mp_next[3] = $signed(rc_d_reg.a_hi) * $signed(mb_hi_reg);
    end

    // shift right with truncation toward zero, then clamp
    always_comb
    begin
        tq_sat_next = mp_sat_reg;
        for (int i = 0; i < 4; i++)
        begin
            if (mp_reg[i] < 0)
            begin
                tq_c[i] = clamp_w((mp_reg[i] + (2*W)'((1 << F) - 1)) >>> F);
            end
            else
            begin
                tq_c[i] = clamp_w(mp_reg[i] >>> F);
            end
            tq_sat_next = tq_sat_next || tq_c[i].sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rc_d_reg   <= dd_reg[QW];
            mb_lo_reg  <= mb_lo_next;
            mb_hi_reg  <= mb_hi_next;
            rsat_reg   <= rsat_next;
            mp_d_reg   <= rc_d_reg;
            mp_sat_reg <= rsat_reg;
            tq_d_reg   <= mp_d_reg;
            tq_sat_reg <= tq_sat_next;
            for (int i = 0; i < 4; i++)
            begin
                mp_reg[i] <= mp_next[i];
                tq_reg[i] <= tq_c[i].v;
            end
            res_lo_reg <= res_lo_next;
            res_hi_reg <= res_hi_next;
            status_reg <= status_next;
        end
    end

    // final select
    always_comb
    begin
        iau_pkg::val_t mn01, mn23, mx01, mx23;
        clamp_t        c_lo, c_hi;
        logic          sat;
        mn01 = ($signed(tq_reg[1]) < $signed(tq_reg[0])) ? tq_reg[1] : tq_reg[0];
        mn23 = ($signed(tq_reg[3]) < $signed(tq_reg[2])) ? tq_reg[3] : tq_reg[2];
        mx01 = ($signed(tq_reg[1]) > $signed(tq_reg[0])) ? tq_reg[1] : tq_reg[0];
        mx23 = ($signed(tq_reg[3]) > $signed(tq_reg[2])) ? tq_reg[3] : tq_reg[2];
        c_lo = '0;
        c_hi = '0;
        sat  = 1'b0;
        res_lo_next = '0;
        res_hi_next = '0;
        if (tq_d_reg.op.add)
        begin
            c_lo = clamp_w((2*W)'($signed(tq_d_reg.a_lo)) + (2*W)'($signed(tq_d_reg.b_lo)));
            c_hi = clamp_w((2*W)'($signed(tq_d_reg.a_hi)) + (2*W)'($signed(tq_d_reg.b_hi)));
            res_lo_next = c_lo.v;
            res_hi_next = c_hi.v;
            sat = c_lo.sat || c_hi.sat;
        end
        else if (tq_d_reg.op.sub)
        begin
            c_lo = clamp_w((2*W)'($signed(tq_d_reg.a_lo)) - (2*W)'($signed(tq_d_reg.b_hi)));
            c_hi = clamp_w((2*W)'($signed(tq_d_reg.a_hi)) - (2*W)'($signed(tq_d_reg.b_lo)));
            res_lo_next = c_lo.v;
            res_hi_next = c_hi.v;
            sat = c_lo.sat || c_hi.sat;
        end
        else if (tq_d_reg.op.hull)
        begin
            res_lo_next = ($signed(tq_d_reg.b_lo) < $signed(tq_d_reg.a_lo)) ?
                          tq_d_reg.b_lo : tq_d_reg.a_lo;
            res_hi_next = ($signed(tq_d_reg.b_hi) > $signed(tq_d_reg.a_hi)) ?
                          tq_d_reg.b_hi : tq_d_reg.a_hi;
        end
        else if ((tq_d_reg.op.mul || tq_d_reg.op.div) && !tq_d_reg.span)
        begin
            res_lo_next = ($signed(mn23) < $signed(mn01)) ? mn23 : mn01;
            res_hi_next = ($signed(mx23) > $signed(mx01)) ? mx23 : mx01;
            sat = tq_sat_reg;
        end
        if (tq_d_reg.span)
        begin
            status_next = iau_pkg::ST_SPAN;
        end
        else if (sat)
        begin
            status_next = iau_pkg::ST_SAT;
        end
        else
        begin
            status_next = iau_pkg::ST_OK;
        end
    end

    assign out_valid = out_v_reg;
    assign res_lo    = res_lo_reg;
    assign res_hi    = res_hi_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

[hw/rtl/interval_arithmetic_unit.sv]
// interval arithmetic unit, signed Q16.16
// input stream s_*: one beat carries an operation kind and two intervals
//   a = [a_lo, a_hi], b = [b_lo, b_hi]; kinds are add, subtract, multiply,
//   divide (a times [1/b_hi, 1/b_lo]) and hull; a scalar b has b_lo == b_hi
// output stream m_*: exactly one result beat per input beat, in order,
//   holding [res_lo, res_hi] and a status (ok, divisor spans zero, saturated)
// throughput: one beat per cycle sustained while the receiver keeps m_tready high,
//   independent of the operation; the back pipeline holds the 33 stages of the
//   pipelined restoring divider for the reciprocals, then operand select,
//   multiply, truncate/clamp and result select stages
// the front decodes each beat and flags a zero-spanning divisor, then
//   writes it into a small queue; the back pipeline drains that queue
// when the receiver stalls, the back pipeline freezes as a whole while the
//   queue keeps taking beats until it fills, then s_tready drops
// reset (rst_n low, asynchronous) empties queue and pipeline; no result
//   beat is lost or repeated across a stall
`timescale 1ns / 1ps
`default_nettype none
`include "interval_arithmetic_unit_macros.svh"

module interval_arithmetic_unit #(
    parameter int QUEUE_DEPTH = iau_pkg::QUEUE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // kind[2:0], a_lo[34:3], a_hi[66:35], b_lo[98:67], b_hi[130:99], zero pad
    input  logic [iau_pkg::IN_W-1:0] s_tdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // res_lo[31:0], res_hi[63:32], status[65:64], zero pad
    output logic [iau_pkg::OUT_W-1:0] m_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready
);

    localparam int W = iau_pkg::WIDTH;

    iau_pkg::desc_t   fr_desc;
    iau_pkg::desc_t   q_desc;
    logic             q_rd_valid;
    logic             bk_in_ready;
    iau_pkg::val_t    res_lo;
    iau_pkg::val_t    res_hi;
    iau_pkg::status_t status;

    // decode and divisor classification
    iau_front u_front (
        .kind (s_tdata[2:0]),
        .a_lo (s_tdata[3 +: W]),
        .a_hi (s_tdata[3 + W +: W]),
        .b_lo (s_tdata[3 + 2*W +: W]),
        .b_hi (s_tdata[3 + 3*W +: W]),
        .desc (fr_desc)
    );

    // decouples input acceptance from pipeline stalls
    iau_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  (fr_desc),
        .rd_valid (q_rd_valid),
        .rd_ready (bk_in_ready),
        .rd_data  (q_desc)
    );

    // reciprocal, multiply and result pipeline
    iau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_rd_valid),
        .in_ready  (bk_in_ready),
        .in_desc   (q_desc),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res_lo    (res_lo),
        .res_hi    (res_hi),
        .status    (status)
    );

    assign m_tdata = {{(iau_pkg::OUT_W - 2*W - 2){1'b0}}, status, res_hi, res_lo};

    // a zero-spanning divisor always gives the zero interval
    `IAU_ASSERT_IMP(a_span_zero, m_tvalid && (status == iau_pkg::ST_SPAN), (res_lo == '0) && (res_hi == '0))
    // the back pipeline only holds off the queue while the output is stalled
    `IAU_ASSERT_IMP(a_back_stall, !bk_in_ready, m_tvalid && !m_tready)
    // a beat taken at the input is in the queue on the next cycle
    `IAU_ASSERT_NEXT(a_queue_fill, s_tvalid && s_tready, q_rd_valid)

endmodule

`default_nettype wire

[tb/iau_result_checker.sv]
`timescale 1ns / 1ps

module iau_result_checker
    import iau_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IN_W-1:0]     s_tdata,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [OUT_W-1:0]    m_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    output int                  fail_count,
    output int                  pending
);

    localparam longint VMAX = (64'sd1 <<< (WIDTH - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;

    typedef struct packed {
        val_t    lo;
        val_t    hi;
        status_t st;
    } iv_result_t;

    iv_result_t expected_results[$];

    function automatic longint clamp_val(longint v, ref bit sat);
        if (v > VMAX)
        begin
            sat = 1;
            return VMAX;
        end
        if (v < VMIN)
        begin
            sat = 1;
            return VMIN;
        end
        return v;
    endfunction

    // fixed-point product, truncated toward zero
    function automatic longint fx_mul(longint x, longint y, ref bit sat);
        logic signed [127:0] p;
        logic signed [127:0] q;
        p = 128'(x) * 128'(y);
        if (p < 0)
            q = -((-p) >>> FRAC_BITS);
        else
            q = p >>> FRAC_BITS;
        if (q > VMAX)
        begin
            sat = 1;
            return VMAX;
        end
        if (q < VMIN)
        begin
            sat = 1;
            return VMIN;
        end
        return longint'(q);
    endfunction

    function automatic longint fx_recip(longint b, ref bit sat);
        longint m;
        longint q;
        m = (b < 0) ? -b : b;
        q = (64'sd1 <<< (2 * FRAC_BITS)) / m;
        return clamp_val((b < 0) ? -q : q, sat);
    endfunction

    function automatic void span_mul(longint alo, longint ahi, longint blo, longint bhi,
                                     ref longint rlo, ref longint rhi, ref bit sat);
        longint p[4];
        p[0] = fx_mul(alo, blo, sat);
        p[1] = fx_mul(alo, bhi, sat);
        p[2] = fx_mul(ahi, blo, sat);
        p[3] = fx_mul(ahi, bhi, sat);
        rlo = p[0];
        rhi = p[0];
        for (int i = 1; i < 4; i++)
        begin
            if (p[i] < rlo) rlo = p[i];
            if (p[i] > rhi) rhi = p[i];
        end
    endfunction

    function automatic iv_result_t interval_op(logic [IN_W-1:0] d);
        logic [2:0] k;
        longint alo, ahi, blo, bhi, rlo, rhi, bmn, bmx, r1, r2;
        bit sat;
        iv_result_t r;
        k = d[2:0];
        alo = longint'(val_t'(d[34:3]));
        ahi = longint'(val_t'(d[66:35]));
        blo = longint'(val_t'(d[98:67]));
        bhi = longint'(val_t'(d[130:99]));
        rlo = 0;
        rhi = 0;
        sat = 0;
        r.st = ST_OK;
        case (k)
            KIND_ADD:
            begin
                rlo = clamp_val(alo + blo, sat);
                rhi = clamp_val(ahi + bhi, sat);
            end
            KIND_SUB:
            begin
                rlo = clamp_val(alo - bhi, sat);
                rhi = clamp_val(ahi - blo, sat);
            end
            KIND_MUL: span_mul(alo, ahi, blo, bhi, rlo, rhi, sat);
            KIND_DIV:
            begin
                bmn = (blo < bhi) ? blo : bhi;
                bmx = (blo < bhi) ? bhi : blo;
                if (bmn <= 0 && bmx >= 0)
                    r.st = ST_SPAN;
                else
                begin
                    r1 = fx_recip(bhi, sat);
                    r2 = fx_recip(blo, sat);
                    span_mul(alo, ahi, (r1 < r2) ? r1 : r2, (r1 < r2) ? r2 : r1,
                             rlo, rhi, sat);
                end
            end
            KIND_HULL:
            begin
                rlo = (blo < alo) ? blo : alo;
                rhi = (bhi > ahi) ? bhi : ahi;
            end
            default: ;
        endcase
        if (r.st == ST_OK && sat)
            r.st = ST_SAT;
        r.lo = val_t'(rlo);
        r.hi = val_t'(rhi);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin
        iv_result_t want;
        iv_result_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(interval_op(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got.lo = val_t'(m_tdata[31:0]);
                got.hi = val_t'(m_tdata[63:32]);
                got.st = m_tdata[65:64];
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result beat, res_lo", got.lo, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.lo != want.lo) report_mismatch("res_lo", got.lo, want.lo);
                    if (got.hi != want.hi) report_mismatch("res_hi", got.hi, want.hi);
                    if (got.st != want.st) report_mismatch("status", got.st, want.st);
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

[tb/tb_interval_arithmetic_unit.sv]
`timescale 1ns / 1ps

module tb_interval_arithmetic_unit;
    import iau_pkg::*;

    localparam int N_RANDOM  = 500;
    localparam int IDLE_LIMIT = 2000;

    logic             clk;
    logic             rst_n;
    logic [IN_W-1:0]  s_tdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tvalid;
    logic             m_tready;
    int               fail_count;
    int               pending;
    bit               calm;
    int               idle_cycles;

    interval_arithmetic_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    iau_result_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver stalls at random with a probability of 29 in 100, except in calm stretches
    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(99) >= 29);
    end

    // stall watchdog: cycles with no beat accepted on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [31:0] rand_end();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(131072)) - 65536);
            3: return 32'($signed($urandom_range(2048)) - 1024) <<< 16;
            4: return $urandom_range(3) - 1;
            default: return $urandom;
        endcase
    endfunction

    // one beat, held until accepted; random sender gaps ahead of it
    task automatic send_beat(logic [2:0] k, logic [31:0] alo, logic [31:0] ahi,
                             logic [31:0] blo, logic [31:0] bhi);
        while (!calm && $urandom_range(99) < 29)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {5'd0, bhi, blo, ahi, alo, k};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] x, y, u, v;
        logic [2:0]  k;
        rst_n       = 0;
        s_tvalid    = 0;
        s_tdata     = '0;
        m_tready    = 0;
        calm        = 0;
        idle_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every operation and the unused kinds on extremes, one-valued and scalar operands
        send_beat(KIND_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h1, 32'h1);
        send_beat(KIND_ADD, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h0);
        send_beat(KIND_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h1);
        send_beat(KIND_SUB, 32'h0001_0000, 32'h0003_0000, 32'h0001_0000, 32'h0002_0000);
        send_beat(KIND_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_beat(KIND_MUL, 32'hffff_0000, 32'h0002_0000, 32'h0003_0000, 32'hfffd_0000);
        send_beat(KIND_MUL, 32'hffff_ffff, 32'h1, 32'h1, 32'hffff_ffff);
        send_beat(KIND_DIV, 32'h0001_0000, 32'h0002_0000, 32'hffff_0000, 32'h0001_0000);
        send_beat(KIND_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
        send_beat(KIND_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0002_0000);
        send_beat(KIND_DIV, 32'h0001_0000, 32'h0002_0000, 32'h1, 32'h1);
        send_beat(KIND_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(KIND_DIV, 32'h0003_0000, 32'h0003_0000, 32'hfffe_0000, 32'hfffe_0000);
        send_beat(KIND_DIV, 32'h0003_0000, 32'hfffd_0000, 32'h0004_0000, 32'h0002_0000);
        send_beat(KIND_DIV, 32'h1, 32'h2, 32'h7fff_ffff, 32'h8000_0000);
        send_beat(KIND_HULL, 32'h0001_0000, 32'h0002_0000, 32'h8000_0000, 32'h7fff_ffff);
        send_beat(KIND_HULL, 32'h0005_0000, 32'h0001_0000, 32'h0003_0000, 32'h0002_0000);
        send_beat(3'd5, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(3'd6, 32'h1, 32'h2, 32'h3, 32'h4);
        send_beat(3'd7, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            calm = (i >= 200 && i < 280);
            k = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                          : 3'($urandom_range(4));
            x = rand_end();
            y = ($urandom_range(3) == 0) ? rand_end() : x + $urandom_range(65536 * 4);
            u = rand_end();
            v = ($urandom_range(3) == 0) ? u : u + $urandom_range(65536 * 4);
            send_beat(k, x, y, u, v);
        end
        s_tvalid <= 1'b0;
        calm = 0;

        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
